// ----- rtl/core/rap_pkg.sv -----
package rap_pkg;

    localparam logic [15:0] HDR_BYTES        = 16'd20;
    localparam logic [15:0] AUTH_SPLIT       = 16'd12;
    localparam logic [7:0]  TIMEOUT_ATTR_LEN = 8'd6;
    localparam logic [7:0]  MIN_ATTR_LEN     = 8'd2;

    // Attribute type codes held after reset.
    localparam logic [7:0] DEF_REPLY_MSG = 8'd18;
    localparam logic [7:0] DEF_FILTER    = 8'd11;
    localparam logic [7:0] DEF_STATE     = 8'd24;
    localparam logic [7:0] DEF_SESSION   = 8'd27;
    localparam logic [7:0] DEF_IDLE      = 8'd28;

    // Configuration register indexes.
    localparam logic [2:0] CFG_REPLY_MSG = 3'd0;
    localparam logic [2:0] CFG_FILTER    = 3'd1;
    localparam logic [2:0] CFG_STATE     = 3'd2;
    localparam logic [2:0] CFG_SESSION   = 3'd3;
    localparam logic [2:0] CFG_IDLE      = 3'd4;

    typedef enum logic [1:0] {
        KIND_VALUE   = 2'd0,
        KIND_END     = 2'd1,
        KIND_DROP    = 2'd2,
        KIND_SUMMARY = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SHORT = 2'd1,
        ST_LEN   = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        PH_HDR  = 2'd0,
        PH_TYPE = 2'd1,
        PH_LEN  = 2'd2,
        PH_VAL  = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        CL_REPLY   = 3'd0,
        CL_FILTER  = 3'd1,
        CL_STATE   = 3'd2,
        CL_SESSION = 3'd3,
        CL_IDLE    = 3'd4,
        CL_OTHER   = 3'd5
    } t_class;

    typedef struct packed {
        logic [7:0] reply_msg;
        logic [7:0] filter_code;
        logic [7:0] state;
        logic [7:0] session;
        logic [7:0] idle;
    } t_cfg;

    // Up to three results caused by one input beat, in delivery order.
    typedef struct packed {
        logic        val_vld;
        logic [7:0]  val_byte;
        logic        mark_vld;
        logic        mark_drop;
        logic [1:0]  attr;
        logic        sum_vld;
        t_status     status;
        logic [7:0]  code;
        logic [7:0]  ident;
        logic [63:0] auth_high;
        logic [63:0] auth_low;
        logic [31:0] session;
        logic [31:0] idle;
    } t_bundle;

    // The first matching register wins when several hold the same code.
    function automatic t_class classify(input logic [7:0] t, input t_cfg cfg);
        t_class c;
        if (t == cfg.reply_msg)        c = CL_REPLY;
        else if (t == cfg.filter_code) c = CL_FILTER;
        else if (t == cfg.state)       c = CL_STATE;
        else if (t == cfg.session)     c = CL_SESSION;
        else if (t == cfg.idle)        c = CL_IDLE;
        else                           c = CL_OTHER;
        return c;
    endfunction

    function automatic logic is_string(input t_class c);
        return (c == CL_REPLY) || (c == CL_FILTER) || (c == CL_STATE);
    endfunction

endpackage

// ----- rtl/core/response_attribute_parser_top.sv -----
// Parses a RADIUS response delivered one byte per beat, last byte flagged by tlast.
// The parser updates its header and attribute state in the cycle a byte is accepted
// and loads the results of that byte into one output register, which drains one
// result per beat. A byte that causes at most one result is taken every cycle while
// the downstream side takes each result; a byte that causes two or three (a value
// byte with its end marker, a dropped marker, the packet summary) holds the input
// while that register drains and while the downstream side stalls. Configuration writes
// are always accepted and must only be issued while the block is idle.
module response_attribute_parser_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // data_byte
    input  logic         i_s_axis_tlast,   // last_byte
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [223:0] o_m_axis_tdata,   // value_byte[7:0], status[9:8], code_out[17:10],
                                           // identifier_out[25:18], auth_high[89:26],
                                           // auth_low[153:90], session_timeout_out[185:154],
                                           // idle_timeout_out[217:186], zero[223:218]
    output logic [3:0]   o_m_axis_tuser,   // kind[1:0], string_attr[3:2]
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [7:0]   i_cfg_data
);

    rap_pkg::t_cfg    r_cfg;
    rap_pkg::t_bundle bundle;
    logic             in_fire;

    assign o_cfg_ready = 1'b1;
    assign in_fire     = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reply_msg   <= rap_pkg::DEF_REPLY_MSG;
            r_cfg.filter_code <= rap_pkg::DEF_FILTER;
            r_cfg.state       <= rap_pkg::DEF_STATE;
            r_cfg.session     <= rap_pkg::DEF_SESSION;
            r_cfg.idle        <= rap_pkg::DEF_IDLE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                rap_pkg::CFG_REPLY_MSG: r_cfg.reply_msg   <= i_cfg_data;
                rap_pkg::CFG_FILTER:    r_cfg.filter_code <= i_cfg_data;
                rap_pkg::CFG_STATE:     r_cfg.state       <= i_cfg_data;
                rap_pkg::CFG_SESSION:   r_cfg.session     <= i_cfg_data;
                rap_pkg::CFG_IDLE:      r_cfg.idle        <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    rap_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_fire   (in_fire),
        .i_data   (i_s_axis_tdata),
        .i_last   (i_s_axis_tlast),
        .o_bundle (bundle)
    );

    rap_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (in_fire),
        .i_bundle   (bundle),
        .o_in_ready (o_s_axis_tready),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_tdata    (o_m_axis_tdata),
        .o_tuser    (o_m_axis_tuser)
    );

    // Every packet end produces a summary beat.
    a_summary_follows_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire && i_s_axis_tlast |=> o_m_axis_tvalid)
        else $error("no result pending after the last byte of a packet");

    // A stalled result leaves no room for a new byte's results.
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |-> !o_s_axis_tready)
        else $error("input accepted while the result register is stalled");

    // A summary never carries an undefined status code.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser[1:0] == rap_pkg::KIND_SUMMARY)
        |-> (o_m_axis_tdata[9:8] != 2'd3))
        else $error("summary with an undefined status code");

endmodule

// ----- rtl/core/rap_parser.sv -----
module rap_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  rap_pkg::t_cfg    i_cfg,
    input  logic             i_fire,
    input  logic [7:0]       i_data,
    input  logic             i_last,
    output rap_pkg::t_bundle o_bundle
);

    logic [15:0]     r_byte_count, n_byte_count;
    logic [15:0]     r_hdr_len,    n_hdr_len;
    logic [7:0]      r_code,       n_code;
    logic [7:0]      r_ident,      n_ident;
    logic [63:0]     r_auth0,      n_auth0;
    logic [63:0]     r_auth1,      n_auth1;
    rap_pkg::t_phase r_phase,      n_phase;
    logic [7:0]      r_attr_type,  n_attr_type;
    logic [7:0]      r_attr_len,   n_attr_len;
    logic [7:0]      r_attr_pos,   n_attr_pos;
    logic            r_stopped,    n_stopped;
    logic [31:0]     r_accum,      n_accum;
    logic [31:0]     r_session,    n_session;
    logic [31:0]     r_idle,       n_idle;

    rap_pkg::t_class c_cur;
    rap_pkg::t_class c_new;
    logic            finish;

    always_comb begin
        n_byte_count = r_byte_count;
        n_hdr_len    = r_hdr_len;
        n_code       = r_code;
        n_ident      = r_ident;
        n_auth0      = r_auth0;
        n_auth1      = r_auth1;
        n_phase      = r_phase;
        n_attr_type  = r_attr_type;
        n_attr_len   = r_attr_len;
        n_attr_pos   = r_attr_pos;
        n_stopped    = r_stopped;
        n_accum      = r_accum;
        n_session    = r_session;
        n_idle       = r_idle;
        o_bundle     = '0;
        finish       = 1'b0;
        c_cur        = rap_pkg::classify(r_attr_type, i_cfg);

        if (r_byte_count != 16'hFFFF) begin
            n_byte_count = r_byte_count + 16'd1;
        end

        if (r_byte_count < rap_pkg::HDR_BYTES) begin
            if (r_byte_count == 16'd0) begin
                n_code = i_data;
            end else if (r_byte_count == 16'd1) begin
                n_ident = i_data;
            end else if (r_byte_count == 16'd2) begin
                n_hdr_len = {i_data, 8'h00};
            end else if (r_byte_count == 16'd3) begin
                n_hdr_len = {r_hdr_len[15:8], i_data};
            end else if (r_byte_count < rap_pkg::AUTH_SPLIT) begin
                n_auth0 = {r_auth0[55:0], i_data};
            end else begin
                n_auth1 = {r_auth1[55:0], i_data};
            end
            if (r_byte_count == rap_pkg::HDR_BYTES - 16'd1) begin
                n_phase = rap_pkg::PH_TYPE;
            end
        end else if (!r_stopped) begin
            unique case (r_phase)
                rap_pkg::PH_HDR: begin
                end
                rap_pkg::PH_TYPE: begin
                    n_attr_type = i_data;
                    n_phase     = rap_pkg::PH_LEN;
                end
                rap_pkg::PH_LEN: begin
                    n_attr_len = i_data;
                    n_attr_pos = '0;
                    n_accum    = '0;
                    if (i_data < rap_pkg::MIN_ATTR_LEN) begin
                        n_stopped = 1'b1;
                        n_phase   = rap_pkg::PH_TYPE;
                    end else if (i_data == rap_pkg::MIN_ATTR_LEN) begin
                        finish = 1'b1;
                    end else begin
                        n_phase = rap_pkg::PH_VAL;
                    end
                end
                rap_pkg::PH_VAL: begin
                    n_attr_pos = r_attr_pos + 8'd1;
                    n_accum    = {r_accum[23:0], i_data};
                    if (rap_pkg::is_string(c_cur)) begin
                        o_bundle.val_vld  = 1'b1;
                        o_bundle.val_byte = i_data;
                        o_bundle.attr     = c_cur[1:0];
                    end
                    if ({1'b0, n_attr_pos} + {1'b0, rap_pkg::MIN_ATTR_LEN}
                        >= {1'b0, r_attr_len}) begin
                        finish = 1'b1;
                    end
                end
            endcase
        end

        // A completed attribute: end marker for strings, keep a well-formed timeout.
        if (finish) begin
            if (rap_pkg::is_string(c_cur)) begin
                o_bundle.mark_vld = 1'b1;
                o_bundle.attr     = c_cur[1:0];
            end else if (n_attr_len == rap_pkg::TIMEOUT_ATTR_LEN) begin
                if (c_cur == rap_pkg::CL_SESSION) begin
                    n_session = n_accum;
                end else if (c_cur == rap_pkg::CL_IDLE) begin
                    n_idle = n_accum;
                end
            end
            n_phase = rap_pkg::PH_TYPE;
        end

        c_new = rap_pkg::classify(n_attr_type, i_cfg);

        if (i_last) begin
            if (!n_stopped && (n_phase == rap_pkg::PH_LEN || n_phase == rap_pkg::PH_VAL)
                && rap_pkg::is_string(c_new)) begin
                o_bundle.mark_vld  = 1'b1;
                o_bundle.mark_drop = 1'b1;
                o_bundle.attr      = c_new[1:0];
            end
            o_bundle.sum_vld = 1'b1;
            if (n_byte_count < rap_pkg::HDR_BYTES) begin
                o_bundle.status = rap_pkg::ST_SHORT;
            end else if (n_hdr_len > n_byte_count) begin
                o_bundle.status = rap_pkg::ST_LEN;
            end else begin
                o_bundle.status    = rap_pkg::ST_OK;
                o_bundle.code      = n_code;
                o_bundle.ident     = n_ident;
                o_bundle.auth_high = n_auth0;
                o_bundle.auth_low  = n_auth1;
                o_bundle.session   = n_session;
                o_bundle.idle      = n_idle;
            end
            n_byte_count = '0;
            n_hdr_len    = '0;
            n_code       = '0;
            n_ident      = '0;
            n_auth0      = '0;
            n_auth1      = '0;
            n_phase      = rap_pkg::PH_HDR;
            n_attr_type  = '0;
            n_attr_len   = '0;
            n_attr_pos   = '0;
            n_stopped    = 1'b0;
            n_accum      = '0;
            n_session    = '0;
            n_idle       = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_hdr_len    <= '0;
            r_code       <= '0;
            r_ident      <= '0;
            r_auth0      <= '0;
            r_auth1      <= '0;
            r_phase      <= rap_pkg::PH_HDR;
            r_attr_type  <= '0;
            r_attr_len   <= '0;
            r_attr_pos   <= '0;
            r_stopped    <= 1'b0;
            r_accum      <= '0;
            r_session    <= '0;
            r_idle       <= '0;
        end else if (i_fire) begin
            r_byte_count <= n_byte_count;
            r_hdr_len    <= n_hdr_len;
            r_code       <= n_code;
            r_ident      <= n_ident;
            r_auth0      <= n_auth0;
            r_auth1      <= n_auth1;
            r_phase      <= n_phase;
            r_attr_type  <= n_attr_type;
            r_attr_len   <= n_attr_len;
            r_attr_pos   <= n_attr_pos;
            r_stopped    <= n_stopped;
            r_accum      <= n_accum;
            r_session    <= n_session;
            r_idle       <= n_idle;
        end
    end

endmodule

// ----- rtl/core/rap_out_stage.sv -----
module rap_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  rap_pkg::t_bundle i_bundle,
    output logic             o_in_ready,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [223:0]     o_tdata,   // value_byte, status, code_out, identifier_out,
                                        // auth_high, auth_low, session_timeout_out,
                                        // idle_timeout_out, zero pad
    output logic [3:0]       o_tuser    // kind, string_attr
);

    // Pending results: bit 0 value byte, bit 1 marker, bit 2 summary.
    logic [2:0]       r_pend;
    logic [2:0]       n_pend;
    rap_pkg::t_bundle r_bun;
    logic [2:0]       lowest;
    logic             pop;
    rap_pkg::t_kind   kind;

    assign lowest     = r_pend & (~r_pend + 3'd1);
    assign o_valid    = |r_pend;
    assign pop        = o_valid && i_ready;
    assign o_in_ready = (r_pend == 3'd0) || ((r_pend == lowest) && i_ready);

    always_comb begin
        n_pend = pop ? (r_pend & ~lowest) : r_pend;
        if (i_load) begin
            n_pend = {i_bundle.sum_vld, i_bundle.mark_vld, i_bundle.val_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
        if (i_load) begin
            r_bun <= i_bundle;
        end
    end

    always_comb begin
        o_tdata = '0;
        kind    = rap_pkg::KIND_SUMMARY;
        o_tuser = '0;
        if (lowest[0]) begin
            kind          = rap_pkg::KIND_VALUE;
            o_tdata[7:0]  = r_bun.val_byte;
            o_tuser[3:2]  = r_bun.attr;
        end else if (lowest[1]) begin
            kind          = r_bun.mark_drop ? rap_pkg::KIND_DROP : rap_pkg::KIND_END;
            o_tuser[3:2]  = r_bun.attr;
        end else begin
            o_tdata[9:8]     = r_bun.status;
            o_tdata[17:10]   = r_bun.code;
            o_tdata[25:18]   = r_bun.ident;
            o_tdata[89:26]   = r_bun.auth_high;
            o_tdata[153:90]  = r_bun.auth_low;
            o_tdata[185:154] = r_bun.session;
            o_tdata[217:186] = r_bun.idle;
        end
        o_tuser[1:0] = kind;
    end

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 100ps

module tb;

    localparam int QUIET_LIMIT  = 4000;
    localparam int STALL_CYCLES = 400;
    localparam int SETTLE       = 8;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_axis_tvalid;
    logic         o_s_axis_tready;
    logic [7:0]   i_s_axis_tdata;
    logic         i_s_axis_tlast;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready;
    logic [223:0] o_m_axis_tdata;
    logic [3:0]   o_m_axis_tuser;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index;
    logic [7:0]   i_cfg_data;

    response_attribute_parser_top DUT (.*);

    typedef struct {
        rap_pkg::t_kind   kind;
        logic [7:0]       vbyte;
        logic [1:0]       sattr;
        rap_pkg::t_status status;
        logic [7:0]       code;
        logic [7:0]       ident;
        logic [63:0]      auth_hi;
        logic [63:0]      auth_lo;
        logic [31:0]      session;
        logic [31:0]      idle;
    } t_rsp_result;

    typedef struct packed {
        logic [7:0]       data;
        logic             last;
        logic             typed;
        rap_pkg::t_status status;
    } t_dir_row;

    // Attribute type codes as the block currently holds them.
    rap_pkg::t_cfg    codes;

    // Parser state as the block should hold it.
    logic [15:0]      rsp_count;
    logic [15:0]      rsp_hlen;
    logic [7:0]       rsp_code;
    logic [7:0]       rsp_ident;
    logic [63:0]      rsp_auth_hi;
    logic [63:0]      rsp_auth_lo;
    rap_pkg::t_phase  rsp_phase;
    logic [7:0]       rsp_type;
    logic [7:0]       rsp_len;
    logic [7:0]       rsp_pos;
    logic             rsp_stopped;
    logic [31:0]      rsp_acc;
    logic [31:0]      rsp_session;
    logic [31:0]      rsp_idle;

    t_rsp_result      pending_results [$];
    logic [7:0]       pkt_bytes [$];
    t_dir_row         directed_rows [25];

    logic             row_typed;
    rap_pkg::t_status row_status;
    logic             stall_req;
    int               tx_gap_max;
    int               rx_gap_max;
    int               bytes_sent;
    int               bytes_taken;
    int               results_seen;
    int               values_seen;
    int               drops_seen;
    int               summaries_seen;
    int               mismatches;
    int               quiet_cycles;
    int               settings_used;

    initial i_clk = 1'b0;
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic rap_pkg::t_class attr_class(input logic [7:0] t);
        if (t == codes.reply_msg) return rap_pkg::CL_REPLY;
        if (t == codes.filter_code) return rap_pkg::CL_FILTER;
        if (t == codes.state) return rap_pkg::CL_STATE;
        if (t == codes.session) return rap_pkg::CL_SESSION;
        if (t == codes.idle) return rap_pkg::CL_IDLE;
        return rap_pkg::CL_OTHER;
    endfunction

    function automatic void expect_result(input rap_pkg::t_kind k, input logic [7:0] vb,
                                          input logic [1:0] sa);
        t_rsp_result r;
        r.kind    = k;
        r.vbyte   = vb;
        r.sattr   = sa;
        r.status  = rap_pkg::ST_OK;
        r.code    = '0;
        r.ident   = '0;
        r.auth_hi = '0;
        r.auth_lo = '0;
        r.session = '0;
        r.idle    = '0;
        pending_results.push_back(r);
    endfunction

    function automatic void clear_packet_state();
        rsp_count   = '0;
        rsp_hlen    = '0;
        rsp_code    = '0;
        rsp_ident   = '0;
        rsp_auth_hi = '0;
        rsp_auth_lo = '0;
        rsp_phase   = rap_pkg::PH_HDR;
        rsp_type    = '0;
        rsp_len     = '0;
        rsp_pos     = '0;
        rsp_stopped = 1'b0;
        rsp_acc     = '0;
        rsp_session = '0;
        rsp_idle    = '0;
    endfunction

    // A complete attribute closes a string with its end marker, or keeps a timeout.
    function automatic void close_attr();
        rap_pkg::t_class c;
        c = attr_class(rsp_type);
        if (c <= rap_pkg::CL_STATE) begin
            expect_result(rap_pkg::KIND_END, 8'h00, 2'(c));
        end else if (rsp_len == rap_pkg::TIMEOUT_ATTR_LEN) begin
            if (c == rap_pkg::CL_SESSION) rsp_session = rsp_acc;
            else if (c == rap_pkg::CL_IDLE) rsp_idle = rsp_acc;
        end
        rsp_phase = rap_pkg::PH_TYPE;
    endfunction

    function automatic void parse_rsp_byte(input logic [7:0] b, input logic last);
        logic [15:0]      pos;
        rap_pkg::t_class  c;
        rap_pkg::t_status st;
        pos = rsp_count;
        if (rsp_count != 16'hFFFF) rsp_count = rsp_count + 16'd1;

        if (pos < rap_pkg::HDR_BYTES) begin
            if (pos == 0) rsp_code = b;
            else if (pos == 1) rsp_ident = b;
            else if (pos == 2) rsp_hlen = {b, 8'h00};
            else if (pos == 3) rsp_hlen = {rsp_hlen[15:8], b};
            else if (pos < rap_pkg::AUTH_SPLIT) rsp_auth_hi = {rsp_auth_hi[55:0], b};
            else rsp_auth_lo = {rsp_auth_lo[55:0], b};
            if (pos == rap_pkg::HDR_BYTES - 1) rsp_phase = rap_pkg::PH_TYPE;
        end else if (!rsp_stopped) begin
            case (rsp_phase)
                rap_pkg::PH_TYPE: begin
                    rsp_type  = b;
                    rsp_phase = rap_pkg::PH_LEN;
                end
                rap_pkg::PH_LEN: begin
                    rsp_len = b;
                    rsp_pos = '0;
                    rsp_acc = '0;
                    if (b < rap_pkg::MIN_ATTR_LEN) begin
                        rsp_stopped = 1'b1;
                        rsp_phase   = rap_pkg::PH_TYPE;
                    end else if (b == rap_pkg::MIN_ATTR_LEN) begin
                        close_attr();
                    end else begin
                        rsp_phase = rap_pkg::PH_VAL;
                    end
                end
                rap_pkg::PH_VAL: begin
                    c = attr_class(rsp_type);
                    rsp_pos = rsp_pos + 8'd1;
                    rsp_acc = {rsp_acc[23:0], b};
                    if (c <= rap_pkg::CL_STATE) expect_result(rap_pkg::KIND_VALUE, b, 2'(c));
                    if (int'(rsp_pos) + int'(rap_pkg::MIN_ATTR_LEN) >= int'(rsp_len))
                        close_attr();
                end
                default: ;
            endcase
        end

        if (last) begin
            if (!rsp_stopped && (rsp_phase == rap_pkg::PH_LEN
                    || rsp_phase == rap_pkg::PH_VAL)) begin
                c = attr_class(rsp_type);
                if (c <= rap_pkg::CL_STATE) expect_result(rap_pkg::KIND_DROP, 8'h00, 2'(c));
            end
            if (rsp_count < rap_pkg::HDR_BYTES) st = rap_pkg::ST_SHORT;
            else if (rsp_hlen > rsp_count) st = rap_pkg::ST_LEN;
            else st = rap_pkg::ST_OK;
            expect_result(rap_pkg::KIND_SUMMARY, 8'h00, 2'b00);
            pending_results[$].status = st;
            if (st == rap_pkg::ST_OK) begin
                pending_results[$].code    = rsp_code;
                pending_results[$].ident   = rsp_ident;
                pending_results[$].auth_hi = rsp_auth_hi;
                pending_results[$].auth_lo = rsp_auth_lo;
                pending_results[$].session = rsp_session;
                pending_results[$].idle    = rsp_idle;
            end
            clear_packet_state();
        end
    endfunction

    function automatic void check_field(input string what, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
        end
    endfunction

    // Predict on every accepted byte, check every accepted result, watch for a hang.
    always @(posedge i_clk) begin
        t_rsp_result want;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                parse_rsp_byte(i_s_axis_tdata, i_s_axis_tlast);
                bytes_taken++;
                // A typed table row fixes the summary of an error packet directly.
                if (row_typed) begin
                    void'(pending_results.pop_back());
                    expect_result(rap_pkg::KIND_SUMMARY, 8'h00, 2'b00);
                    pending_results[$].status = row_status;
                end
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                results_seen++;
                case (rap_pkg::t_kind'(o_m_axis_tuser[1:0]))
                    rap_pkg::KIND_VALUE:   values_seen++;
                    rap_pkg::KIND_DROP:    drops_seen++;
                    rap_pkg::KIND_SUMMARY: summaries_seen++;
                    default: ;
                endcase
                if (pending_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: expected no result, actual tuser %0h tdata %0h",
                             $time, o_m_axis_tuser, o_m_axis_tdata);
                end else begin
                    want = pending_results.pop_front();
                    check_field("kind", 64'(want.kind), 64'(o_m_axis_tuser[1:0]));
                    check_field("string_attr", 64'(want.sattr), 64'(o_m_axis_tuser[3:2]));
                    check_field("value_byte", 64'(want.vbyte), 64'(o_m_axis_tdata[7:0]));
                    check_field("status", 64'(want.status), 64'(o_m_axis_tdata[9:8]));
                    check_field("code_out", 64'(want.code), 64'(o_m_axis_tdata[17:10]));
                    check_field("identifier_out", 64'(want.ident),
                                64'(o_m_axis_tdata[25:18]));
                    check_field("auth_high", want.auth_hi, o_m_axis_tdata[89:26]);
                    check_field("auth_low", want.auth_lo, o_m_axis_tdata[153:90]);
                    check_field("session_timeout_out", 64'(want.session),
                                64'(o_m_axis_tdata[185:154]));
                    check_field("idle_timeout_out", 64'(want.idle),
                                64'(o_m_axis_tdata[217:186]));
                end
            end
            if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready)
                    || (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("%0t: no beat moved for %0d cycles", $time, QUIET_LIMIT);
                    $display("status: fail");
                    $finish;
                end
            end
        end
    end

    // Result side: random stalls per beat, plus one long hold-off on request.
    initial begin : result_sink
        int gap;
        i_m_axis_tready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (stall_req) begin
                i_m_axis_tready = 1'b0;
                repeat (STALL_CYCLES) @(negedge i_clk);
                stall_req = 1'b0;
            end
            gap = $urandom_range(0, rx_gap_max);
            if (gap > 0) begin
                i_m_axis_tready = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            i_m_axis_tready = 1'b1;
            do @(posedge i_clk); while (!(o_m_axis_tvalid && i_m_axis_tready));
            @(negedge i_clk);
        end
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                             input rap_pkg::t_status st);
        int gap;
        gap = $urandom_range(0, tx_gap_max);
        if (gap > 0) begin
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tdata  = b;
        i_s_axis_tlast  = last;
        row_typed       = typed;
        row_status      = st;
        i_s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!(i_s_axis_tvalid && o_s_axis_tready));
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_packet();
        foreach (pkt_bytes[i])
            send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1, 1'b0, rap_pkg::ST_OK);
    endtask

    task automatic wait_drained();
        i_s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            rap_pkg::CFG_REPLY_MSG: codes.reply_msg   = val;
            rap_pkg::CFG_FILTER:    codes.filter_code = val;
            rap_pkg::CFG_STATE:     codes.state       = val;
            rap_pkg::CFG_SESSION:   codes.session     = val;
            rap_pkg::CFG_IDLE:      codes.idle        = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_codes(input logic [7:0] reply, input logic [7:0] filter,
                             input logic [7:0] state, input logic [7:0] session,
                             input logic [7:0] idle);
        write_reg(rap_pkg::CFG_REPLY_MSG, reply);
        write_reg(rap_pkg::CFG_FILTER, filter);
        write_reg(rap_pkg::CFG_STATE, state);
        write_reg(rap_pkg::CFG_SESSION, session);
        write_reg(rap_pkg::CFG_IDLE, idle);
        settings_used++;
    endtask

    function automatic logic [7:0] pick_type();
        case ($urandom_range(0, 7))
            0:       return codes.reply_msg;
            1:       return codes.filter_code;
            2:       return codes.state;
            3, 4:    return codes.session;
            5:       return codes.idle;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_len(input logic [7:0] t);
        int r;
        if ((t == codes.session || t == codes.idle) && $urandom_range(0, 3) != 0)
            return rap_pkg::TIMEOUT_ATTR_LEN;
        r = $urandom_range(0, 29);
        if (r == 0) return 8'($urandom_range(0, 1));
        if (r < 3) return rap_pkg::MIN_ATTR_LEN;
        if (r == 3) return 8'd255;
        if (r == 4) return 8'($urandom_range(13, 254));
        return 8'($urandom_range(3, 12));
    endfunction

    // Mostly well-formed packets with random content; some short, some pure noise,
    // some cut inside the last attribute, some with a header length that lies.
    task automatic build_packet();
        int          roll;
        int          n_attr;
        int          cut;
        logic [7:0]  t;
        logic [7:0]  alen;
        logic [15:0] hl;
        pkt_bytes.delete();
        roll = $urandom_range(0, 19);
        if (roll == 0) begin
            repeat ($urandom_range(1, 19)) pkt_bytes.push_back(8'($urandom));
            return;
        end
        if (roll == 1) begin
            repeat ($urandom_range(20, 60)) pkt_bytes.push_back(8'($urandom));
            return;
        end
        repeat (20) pkt_bytes.push_back(8'($urandom));
        n_attr = $urandom_range(0, 5);
        for (int a = 0; a < n_attr; a++) begin
            t    = pick_type();
            alen = pick_len(t);
            pkt_bytes.push_back(t);
            pkt_bytes.push_back(alen);
            if (alen < rap_pkg::MIN_ATTR_LEN) begin
                repeat ($urandom_range(0, 6)) pkt_bytes.push_back(8'($urandom));
                break;
            end
            repeat (int'(alen) - 2) pkt_bytes.push_back(8'($urandom));
        end
        if (n_attr > 0 && $urandom_range(0, 3) == 0) begin
            cut = $urandom_range(1, 4);
            while (cut > 0 && pkt_bytes.size() > 21) begin
                void'(pkt_bytes.pop_back());
                cut--;
            end
        end
        roll = $urandom_range(0, 9);
        if (roll < 7) hl = 16'(pkt_bytes.size());
        else if (roll < 9) hl = 16'(pkt_bytes.size() + $urandom_range(1, 300));
        else hl = 16'($urandom_range(0, pkt_bytes.size() - 1));
        pkt_bytes[2] = hl[15:8];
        pkt_bytes[3] = hl[7:0];
    endtask

    task automatic run_random(input int n_items);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n_items) begin
            build_packet();
            tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 8;
            send_packet();
        end
    endtask

    initial begin
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tlast  = 1'b0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = '0;
        i_cfg_data      = '0;
        row_typed       = 1'b0;
        row_status      = rap_pkg::ST_OK;
        stall_req       = 1'b0;
        tx_gap_max      = 8;
        rx_gap_max      = 8;
        bytes_sent      = 0;
        bytes_taken     = 0;
        results_seen    = 0;
        values_seen     = 0;
        drops_seen      = 0;
        summaries_seen  = 0;
        mismatches      = 0;
        quiet_cycles    = 0;
        settings_used   = 1;
        codes           = '{reply_msg: rap_pkg::DEF_REPLY_MSG,
                            filter_code: rap_pkg::DEF_FILTER,
                            state: rap_pkg::DEF_STATE,
                            session: rap_pkg::DEF_SESSION,
                            idle: rap_pkg::DEF_IDLE};
        clear_packet_state();

        // A one-byte packet, then a 24-byte packet whose reply message closes on
        // its only value byte and whose state attribute is cut after its type.
        directed_rows = '{
            '{8'hFF, 1'b1, 1'b1, rap_pkg::ST_SHORT},
            '{8'hFF, 1'b0, 1'b0, rap_pkg::ST_OK}, '{8'h00, 1'b0, 1'b0, rap_pkg::ST_OK},
            '{8'h00, 1'b0, 1'b0, rap_pkg::ST_OK}, '{8'h18, 1'b0, 1'b0, rap_pkg::ST_OK},
            '{8'hFF, 1'b0, 1'b0, rap_pkg::ST_OK}, '{8'h00, 1'b0, 1'b0, rap_pkg::ST_OK},
            '{8'h80, 1'b0, 1'b0, rap_pkg::ST_OK}, '{8'h01, 1'b0, 1'b0, rap_pkg::ST_OK},
            '{8'hFE, 1'b0, 1'b0, rap_pkg::ST_OK}, '{8'h7F, 1'b0, 1'b0, rap_pkg::ST_OK},
            '{8'hA5, 1'b0, 1'b0, rap_pkg::ST_OK}, '{8'h5A, 1'b0, 1'b0, rap_pkg::ST_OK},
            '{8'h00, 1'b0, 1'b0, rap_pkg::ST_OK}, '{8'h11, 1'b0, 1'b0, rap_pkg::ST_OK},
            '{8'h22, 1'b0, 1'b0, rap_pkg::ST_OK}, '{8'h33, 1'b0, 1'b0, rap_pkg::ST_OK},
            '{8'h44, 1'b0, 1'b0, rap_pkg::ST_OK}, '{8'h55, 1'b0, 1'b0, rap_pkg::ST_OK},
            '{8'h66, 1'b0, 1'b0, rap_pkg::ST_OK}, '{8'hFF, 1'b0, 1'b0, rap_pkg::ST_OK},
            '{8'h12, 1'b0, 1'b0, rap_pkg::ST_OK}, '{8'h03, 1'b0, 1'b0, rap_pkg::ST_OK},
            '{8'hFF, 1'b0, 1'b0, rap_pkg::ST_OK}, '{8'h18, 1'b1, 1'b0, rap_pkg::ST_OK}
        };

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[i])
            send_byte(directed_rows[i].data, directed_rows[i].last,
                      directed_rows[i].typed, directed_rows[i].status);
        wait_drained();

        // The result side holds off while a long reply message keeps the input busy.
        stall_req = 1'b1;
        pkt_bytes.delete();
        repeat (20) pkt_bytes.push_back(8'($urandom));
        pkt_bytes.push_back(codes.reply_msg);
        pkt_bytes.push_back(8'd60);
        repeat (58) pkt_bytes.push_back(8'($urandom));
        pkt_bytes[2] = 8'h00;
        pkt_bytes[3] = 8'd80;
        send_packet();
        run_random(80);
        wait_drained();

        set_codes(8'hFF, 8'h00, 8'h01, 8'hFE, 8'h80);
        rx_gap_max = 0;
        run_random(70);
        wait_drained();
        rx_gap_max = 8;

        // Every register on one code: the reply message takes precedence.
        set_codes(8'h07, 8'h07, 8'h07, 8'h07, 8'h07);
        run_random(40);
        wait_drained();

        set_codes(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        run_random(50);
        wait_drained();

        $display("Sent %0d bytes in %0d packets under %0d type-code settings.",
                 bytes_taken, summaries_seen, settings_used);
        $display("Checked %0d results: %0d value bytes, %0d dropped markers.",
                 results_seen, values_seen, drops_seen);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/rap_pkg.sv
rtl/core/rap_parser.sv
rtl/core/rap_out_stage.sv
rtl/core/response_attribute_parser_top.sv
tb/sv/tb.sv
